>>> design/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants for the timestamped ring queue
// Operation codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package tsq_pkg;

	localparam int DEFAULT_DEPTH     = 16;
	localparam int DEFAULT_PAYLOAD_W = 32;

	localparam int POS_W   = 4;
	localparam int FILL_W  = 5;
	localparam int STAMP_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

endpackage

>>> design/timestamped_queue_remove_at.sv
// ----------------------------------------------------------------------------
// timestamped_queue_remove_at: ring queue of stamped payloads
// Push, pop, peek at an offset and remove at an offset from the head. Entries
// live in one synchronous memory; remove closes the gap one entry per cycle.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+-------------------------------------
//  request | in        | in_valid/in_stall  | op, payload_in, now_stamp, position
//  result  | out       | out_valid/out_stall| ok, payload_out, stamp_out,
//          |           |                    | fill_count, is_empty, is_full
//
// Push and any refused request go straight to the final state; pop and peek
// first pass through one memory read. Remove at an offset reads its entry, then
// shifts the later entries toward the head: each cycle the shift reads one entry
// and writes the previous one through the single read port. One request is in
// work at a time; a request is taken while the previous result still waits in
// the output register, and a stalled result holds the block in its final state.
// Reset clears head, tail and count; the memory is not cleared.
// ----------------------------------------------------------------------------
module timestamped_queue_remove_at #(
	parameter int DEPTH         = tsq_pkg::DEFAULT_DEPTH,
	parameter int PAYLOAD_WIDTH = tsq_pkg::DEFAULT_PAYLOAD_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tsq_pkg::op_t                 op,
	input  logic [PAYLOAD_WIDTH-1:0]     payload_in,
	input  logic [tsq_pkg::STAMP_W-1:0]  now_stamp,
	input  logic [tsq_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         ok,
	output logic [PAYLOAD_WIDTH-1:0]     payload_out,
	output logic [tsq_pkg::STAMP_W-1:0]  stamp_out,
	output logic [tsq_pkg::FILL_W-1:0]   fill_count,
	output logic                         is_empty,
	output logic                         is_full
);
	import tsq_pkg::*;

	localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int EXT_W   = CNT_W + 1;
	localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int SUM_W   = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;
	localparam int RING_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
	localparam int ENTRY_W = PAYLOAD_WIDTH + STAMP_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   cur_slot_q;
	logic [CNT_W-1:0]    off_q;
	logic                wr_pend_s1;
	logic [SLOT_W-1:0]   wr_slot_s1;

	logic                res_ok_q;
	logic [PAYLOAD_WIDTH-1:0] res_pay_q;
	logic [STAMP_W-1:0]  res_stamp_q;

	logic                out_valid_q;
	logic                ok_q;
	logic [PAYLOAD_WIDTH-1:0] payload_out_q;
	logic [STAMP_W-1:0]  stamp_out_q;
	logic [FILL_W-1:0]   fill_q;
	logic                empty_q;
	logic                full_q;

	logic [ENTRY_W-1:0]  mem [DEPTH];
	logic [ENTRY_W-1:0]  rd_data_q;

	logic                accept;
	logic                cnt_full;
	logic                cnt_zero;
	logic                pos_ok;
	logic [SUM_W-1:0]    pos_sum;
	logic [SLOT_W-1:0]   pos_slot;
	logic                shift_more;
	logic [SLOT_W-1:0]   next_slot;
	logic                out_free;

	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic                rd_en;
	logic [SLOT_W-1:0]   rd_addr;

	logic [RING_W-1:0]   ring_sum;
	logic [SLOT_W-1:0]   ring_tail;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign cnt_full = (count_q == CNT_W'(DEPTH));
	assign cnt_zero = (count_q == '0);
	assign pos_ok   = (CMP_W'(position) < CMP_W'(count_q));
	assign out_free = !out_valid_q || !out_stall;

	// offset is below the count here, so one subtract wraps it
	assign pos_sum  = SUM_W'(head_q) + SUM_W'(position);
	assign pos_slot = (pos_sum >= SUM_W'(DEPTH)) ? SLOT_W'(pos_sum - SUM_W'(DEPTH))
	                                             : SLOT_W'(pos_sum);

	assign shift_more = (EXT_W'(off_q) + EXT_W'(1)) < EXT_W'(count_q);
	assign next_slot  = (cur_slot_q == LAST_SLOT) ? '0 : cur_slot_q + SLOT_W'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = {payload_in, now_stamp};
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUSH: begin
							wr_en = !cnt_full;
						end
						OP_POP: begin
							rd_en = !cnt_zero;
						end
						OP_PEEK, OP_REMOVE: begin
							rd_en   = pos_ok;
							rd_addr = pos_slot;
						end
						default: begin
							rd_en = 1'b0;
						end
					endcase
				end
			end
			S_SHIFT: begin
				// write the entry fetched last cycle one slot toward the head
				wr_en   = wr_pend_s1;
				wr_addr = wr_slot_s1;
				wr_data = rd_data_q;
				rd_en   = shift_more;
				rd_addr = next_slot;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless a new one loads in its place
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= op;
						res_pay_q   <= '0;
						res_stamp_q <= '0;
						cur_slot_q  <= pos_slot;
						off_q       <= CNT_W'(position);
						case (op)
							OP_PUSH: begin
								res_ok_q <= !cnt_full;
								state_q  <= S_DONE;
								if (!cnt_full) begin
									tail_q  <= (tail_q == LAST_SLOT) ? '0 : tail_q + SLOT_W'(1);
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_POP: begin
								res_ok_q <= !cnt_zero;
								state_q  <= cnt_zero ? S_DONE : S_READ;
								if (!cnt_zero) begin
									head_q  <= (head_q == LAST_SLOT) ? '0 : head_q + SLOT_W'(1);
									count_q <= count_q - CNT_W'(1);
								end
							end
							default: begin
								res_ok_q <= pos_ok;
								state_q  <= pos_ok ? S_READ : S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					res_pay_q <= rd_data_q[ENTRY_W-1 -: PAYLOAD_WIDTH];
					if (op_q != OP_POP) begin
						res_stamp_q <= rd_data_q[STAMP_W-1:0];
					end
					state_q <= (op_q == OP_REMOVE) ? S_SHIFT : S_DONE;
				end
				S_SHIFT: begin
					wr_pend_s1 <= shift_more;
					wr_slot_s1 <= cur_slot_q;
					if (shift_more) begin
						cur_slot_q <= next_slot;
						off_q      <= off_q + CNT_W'(1);
					end else begin
						// last pending write lands this cycle; pull the tail back
						tail_q  <= (tail_q == '0) ? LAST_SLOT : tail_q - SLOT_W'(1);
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			ok_q          <= res_ok_q;
			payload_out_q <= res_pay_q;
			stamp_out_q   <= res_stamp_q;
			fill_q        <= FILL_W'(count_q);
			empty_q       <= cnt_zero;
			full_q        <= cnt_full;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign payload_out = payload_out_q;
	assign stamp_out   = stamp_out_q;
	assign fill_count  = fill_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

	// tail must sit count slots past head
	assign ring_sum  = RING_W'(head_q) + RING_W'(count_q);
	assign ring_tail = (ring_sum >= RING_W'(DEPTH)) ? SLOT_W'(ring_sum - RING_W'(DEPTH))
	                                                : SLOT_W'(ring_sum);

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (ring_tail == tail_q))
		else $error("tail pointer disagrees with head and count");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("memory read and write hit the same slot");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result presented outside the final state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(DEPTH)) && !(out_valid && is_empty && is_full))
		else $error("entry count out of range");

endmodule
